[hdl/ttt_pkg.sv]
// ttt_pkg: shared constants, codes and structs for the tick task timer table.
// No dependencies; imported by the interfaces, the slot cell and the top level.
package ttt_pkg;

  localparam int unsigned NumSlots   = 8;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned FieldW     = 16;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_SETIV   = 3'd5,
    CMD_ENABLE  = 3'd6,
    CMD_DISABLE = 3'd7
  } ttt_cmd_e;

  typedef enum logic [1:0] {
    KIND_DUE   = 2'd0,
    KIND_ADDED = 2'd1,
    KIND_FULL  = 2'd2
  } ttt_kind_e;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic                  add;
    logic                  start;
    logic                  stop;
    logic                  remove;
    logic                  setiv;
    logic                  step;
    logic [IdxW-1:0]       slot;
    logic [CountWidth-1:0] delay;
    logic [CountWidth-1:0] interval;
  } ttt_op_t;

  // Handed from each cell to the next higher one.
  typedef struct packed {
    logic            free_seen;
    logic [IdxW-1:0] add_idx;
    logic            emit;
    logic [IdxW-1:0] emit_idx;
    logic            emit_last;
  } ttt_chain_t;

endpackage

[hdl/ttt_if.sv]
// ttt_if: valid/ready channel interfaces for commands and results.
// Depends on ttt_pkg for the field widths.
interface ttt_cmd_if import ttt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [IdxW-1:0]   slot;
  logic [FieldW-1:0] delay;
  logic [FieldW-1:0] interval;

  modport source (output valid, command, slot, delay, interval, input ready);
  modport sink   (input valid, command, slot, delay, interval, output ready);
endinterface

interface ttt_res_if import ttt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [IdxW-1:0] slot_index;
  logic            last;

  modport source (output valid, kind, slot_index, last, input ready);
  modport sink   (input valid, kind, slot_index, last, output ready);
endinterface

[hdl/ttt_cell.sv]
// ttt_cell: one timer slot with its flags, countdown, reload value and tick token.
// Depends on ttt_pkg for the broadcast op and the neighbor chain struct.
module ttt_cell import ttt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttt_op_t         op_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic            tok_i,
  input  ttt_chain_t      chain_i,
  input  logic            due_hi_i,
  output logic            tok_o,
  output ttt_chain_t      chain_o,
  output logic            due_hi_o
);

  logic                  used_q, used_d;
  logic                  run_q, run_d;
  logic                  tok_q, tok_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [CountWidth-1:0] rld_q, rld_d;
  logic                  take, hit, due, act;

  assign take = op_i.add & ~used_q & ~chain_i.free_seen;
  assign hit  = (op_i.slot == idx_i);
  assign due  = used_q & run_q & (cnt_q == '0);
  assign act  = tok_q & op_i.step;

  always_comb begin
    chain_o.free_seen = chain_i.free_seen | ~used_q;
    chain_o.add_idx   = take ? idx_i : chain_i.add_idx;
    chain_o.emit      = chain_i.emit | (tok_q & due);
    chain_o.emit_idx  = (tok_q & due) ? idx_i : chain_i.emit_idx;
    chain_o.emit_last = (tok_q & due) ? ~due_hi_i : chain_i.emit_last;
  end

  assign due_hi_o = due_hi_i | due;
  assign tok_o    = tok_q;

  always_comb begin
    used_d = used_q;
    run_d  = run_q;
    cnt_d  = cnt_q;
    rld_d  = rld_q;
    tok_d  = op_i.step ? tok_i : tok_q;
    if (take) begin
      used_d = 1'b1;
      run_d  = 1'b1;
      cnt_d  = op_i.delay;
      rld_d  = op_i.interval;
    end
    if (op_i.start && hit) begin
      run_d = 1'b1;
      cnt_d = rld_q;
    end
    if (op_i.stop && hit)   run_d  = 1'b0;
    if (op_i.remove && hit) used_d = 1'b0;
    if (op_i.setiv && hit)  rld_d  = op_i.interval;
    // Visit: fire and reload or free, else count down.
    if (act && used_q && run_q) begin
      if (due) begin
        if (rld_q != '0) cnt_d = rld_q;
        else used_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      run_q  <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      run_q  <= run_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rld_q <= rld_d;
  end

endmodule

[hdl/tick_task_timer_table.sv]
// tick_task_timer_table: top level with command decode, result register and
// a row of ttt_cell slots. Depends on ttt_pkg, ttt_if and ttt_cell.
//
//  channel  dir  handshake           payload
//  cmd_i    in   valid/ready         command, slot, delay, interval
//  res_o    out  valid/ready         kind, slot_index, last
//
// Add, start, stop, remove, set interval, enable and disable complete in the
// cycle of their transfer; add loads one result into the output register.
// An enabled tick passes a token through the cells, one slot per cycle, so it
// holds the command channel until the token leaves the highest slot.
// The token advances only while the result register is empty or being taken,
// so a stalled result stalls the sweep. A command transfer also needs that
// register free. Reset clears all flags and enables the scheduler.
module tick_task_timer_table import ttt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttt_cmd_if.sink   cmd_i,
  ttt_res_if.source res_o
);

  logic                busy_q, busy_d;
  logic                en_q, en_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          kind_q, kind_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                last_q, last_d;
  logic                room, acc, tick_go, sweep_end;
  ttt_op_t             op;
  ttt_chain_t          chain [NumSlots+1];
  logic [NumSlots:0]   due_hi;
  logic [NumSlots:0]   tok;

  // The result register is free when empty or being drained this cycle.
  assign room        = ~out_valid_q | res_o.ready;
  assign cmd_i.ready = ~busy_q & room;
  assign acc         = cmd_i.valid & cmd_i.ready;
  assign tick_go     = acc & (cmd_i.command == CMD_TICK) & en_q;

  always_comb begin
    op.add      = acc & (cmd_i.command == CMD_ADD);
    op.start    = acc & (cmd_i.command == CMD_START);
    op.stop     = acc & (cmd_i.command == CMD_STOP);
    op.remove   = acc & (cmd_i.command == CMD_REMOVE);
    op.setiv    = acc & (cmd_i.command == CMD_SETIV);
    op.step     = room;
    op.slot     = cmd_i.slot;
    op.delay    = CountWidth'(cmd_i.delay);
    op.interval = CountWidth'(cmd_i.interval);
  end

  // Chain ends: nothing below the lowest slot, nothing above the highest.
  assign chain[0]         = '0;
  assign tok[0]           = tick_go;
  assign due_hi[NumSlots] = 1'b0;

  for (genvar g = 0; g < NumSlots; g++) begin : g_cell
    ttt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (op),
      .idx_i    (IdxW'(g)),
      .tok_i    (tok[g]),
      .chain_i  (chain[g]),
      .due_hi_i (due_hi[g+1]),
      .tok_o    (tok[g+1]),
      .chain_o  (chain[g+1]),
      .due_hi_o (due_hi[g])
    );
  end

  // The sweep ends when the token leaves the highest slot.
  assign sweep_end = tok[NumSlots] & room;

  always_comb begin
    busy_d = busy_q;
    if (tick_go) busy_d = 1'b1;
    else if (sweep_end) busy_d = 1'b0;
  end

  always_comb begin
    en_d = en_q;
    if (acc) begin
      unique case (cmd_i.command)
        CMD_ENABLE:  en_d = 1'b1;
        CMD_DISABLE: en_d = 1'b0;
        default:     en_d = en_q;
      endcase
    end
  end

  // Load on add or on a visited due slot; drop once taken.
  always_comb begin
    out_valid_d = out_valid_q & ~res_o.ready;
    kind_d      = kind_q;
    idx_d       = idx_q;
    last_d      = last_q;
    if (op.add) begin
      out_valid_d = 1'b1;
      last_d      = 1'b1;
      if (chain[NumSlots].free_seen) begin
        kind_d = KIND_ADDED;
        idx_d  = chain[NumSlots].add_idx;
      end else begin
        kind_d = KIND_FULL;
        idx_d  = '0;
      end
    end else if (room && chain[NumSlots].emit) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_DUE;
      idx_d       = chain[NumSlots].emit_idx;
      last_d      = chain[NumSlots].emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      en_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.slot_index = idx_q;
  assign res_o.last       = last_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok[NumSlots:1]))
    else $error("more than one cell holds the tick token");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok[NumSlots:1] != '0) |-> busy_q)
    else $error("tick token present while idle");

  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.add |=> (res_o.valid && res_o.last && (res_o.kind != KIND_DUE)))
    else $error("add did not produce its result");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> (busy_q && tok[1]))
    else $error("tick did not start the sweep at the lowest slot");
`endif

endmodule
